// ===== hw/rtl/xmltok_pkg.sv =====
`default_nettype none
package xmltok_pkg;

  localparam int unsigned PositionWidthDefault = 16;
  localparam int unsigned TokFieldWidth = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_mode_t;

  typedef enum logic [1:0] {
    TAG_NONE  = 2'd0,
    TAG_OPEN  = 2'd1,
    TAG_CLOSE = 2'd2
  } tag_mode_t;

  typedef enum logic {
    KIND_TEXT = 1'b0,
    KIND_MARK = 1'b1
  } token_kind_t;

  typedef struct packed {
    token_kind_t               kind;
    logic [TokFieldWidth-1:0]  start;
    logic [TokFieldWidth-1:0]  length;
    logic [7:0]                mark;
    logic                      last;
  } token_t;

  typedef struct packed {
    logic [1:0] num;
    token_t     first;
    token_t     second;
  } push_req_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/xmltok_core.sv =====
`default_nettype none
module xmltok_core #(
  parameter int unsigned POSITION_WIDTH = xmltok_pkg::PositionWidthDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             char_byte,
  input  wire logic                   start_of_text,
  input  wire logic                   room,
  output xmltok_pkg::push_req_t       push
);
  import xmltok_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

  logic        held;
  logic [7:0]  chr;
  logic        sot;

  quote_mode_t               quote_mode, quote_mode_next;
  tag_mode_t                 tag_mode, tag_mode_next;
  logic                      prev_bs;
  logic [POSITION_WIDTH-1:0] position, position_next;
  logic [POSITION_WIDTH-1:0] pending_start, pending_start_next;
  logic                      has_text, has_text_next;

  logic advance;

  quote_mode_t               q_cur;
  tag_mode_t                 t_cur;
  logic                      bs_cur;
  logic [POSITION_WIDTH-1:0] idx;
  logic [POSITION_WIDTH-1:0] ps_cur;
  logic                      ht_cur;
  logic                      space;
  logic                      open;
  logic                      mark_hit;
  logic                      flush;
  logic                      emit_text;
  logic [POSITION_WIDTH-1:0] idx_inc;
  logic [POSITION_WIDTH-1:0] text_len;
  token_t                    text_tok;
  token_t                    mark_tok;

  assign advance  = held && room;
  assign in_ready = !held || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      chr <= char_byte;
      sot <= start_of_text;
    end
  end

  always_comb begin
    q_cur  = sot ? QUOTE_NONE : quote_mode;
    t_cur  = sot ? TAG_NONE : tag_mode;
    bs_cur = sot ? 1'b0 : prev_bs;
    idx    = sot ? '0 : position;
    ps_cur = sot ? '0 : pending_start;
    ht_cur = sot ? 1'b0 : has_text;

    space   = is_space(chr);
    idx_inc = (idx == PosMax) ? PosMax : idx + 1'b1;

    quote_mode_next = q_cur;
    if (chr == ChSquote && q_cur != QUOTE_DOUBLE && !bs_cur) begin
      quote_mode_next = (q_cur == QUOTE_NONE) ? QUOTE_SINGLE : QUOTE_NONE;
    end else if (chr == ChDquote && q_cur != QUOTE_SINGLE && !bs_cur) begin
      quote_mode_next = (q_cur == QUOTE_NONE) ? QUOTE_DOUBLE : QUOTE_NONE;
    end

    open     = (t_cur == TAG_OPEN);
    mark_hit = 1'b0;
    flush    = 1'b0;
    if (quote_mode_next == QUOTE_NONE) begin
      if (open && space) begin
        flush = 1'b1;
      end else if (chr == ChLt || chr == ChGt || (open && (chr == ChQuest ||
                   chr == ChBang || chr == ChEq || chr == ChSlash))) begin
        flush    = 1'b1;
        mark_hit = 1'b1;
      end
    end

    tag_mode_next = t_cur;
    if (mark_hit && chr == ChLt) begin
      tag_mode_next = TAG_OPEN;
    end else if (mark_hit && chr == ChGt) begin
      tag_mode_next = TAG_CLOSE;
    end

    emit_text = flush && ht_cur;
    text_len  = (idx >= ps_cur) ? idx - ps_cur : '0;

    pending_start_next = flush ? idx_inc : ps_cur;
    has_text_next      = flush ? 1'b0 : (ht_cur || !space);
    position_next      = idx_inc;

    text_tok.kind   = KIND_TEXT;
    text_tok.start  = TokFieldWidth'(ps_cur);
    text_tok.length = TokFieldWidth'(text_len);
    text_tok.mark   = 8'h00;
    text_tok.last   = !mark_hit;

    mark_tok.kind   = KIND_MARK;
    mark_tok.start  = TokFieldWidth'(idx);
    mark_tok.length = TokFieldWidth'(1);
    mark_tok.mark   = chr;
    mark_tok.last   = 1'b1;

    push.second = mark_tok;
    if (emit_text) begin
      push.first = text_tok;
    end else begin
      push.first = mark_tok;
    end
    if (!advance) begin
      push.num = 2'd0;
    end else begin
      push.num = 2'(emit_text) + 2'(mark_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode    <= QUOTE_NONE;
      tag_mode      <= TAG_NONE;
      prev_bs       <= 1'b0;
      position      <= '0;
      pending_start <= '0;
      has_text      <= 1'b0;
    end else if (advance) begin
      quote_mode    <= quote_mode_next;
      tag_mode      <= tag_mode_next;
      prev_bs       <= (chr == ChBslash);
      position      <= position_next;
      pending_start <= pending_start_next;
      has_text      <= has_text_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/xmltok_outq.sv =====
`default_nettype none
module xmltok_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire xmltok_pkg::push_req_t push,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output xmltok_pkg::token_t         head_tok
);
  import xmltok_pkg::*;

  localparam int unsigned PtrWidth = $clog2(QueueDepth);

  token_t              mem [QueueDepth];
  logic [PtrWidth-1:0] head;
  logic [PtrWidth-1:0] tail;
  logic [PtrWidth:0]   count;
  logic                pop;
  logic [PtrWidth-1:0] tail_plus;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (PtrWidth+1)'(QueueDepth - 2));
  assign head_tok  = mem[head];
  assign tail_plus = tail + 1'b1;

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[tail] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[tail_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      tail  <= tail + PtrWidth'(push.num);
      count <= count + (PtrWidth+1)'(push.num) - (PtrWidth+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/xml_markup_tokenizer_unit.sv =====
`default_nettype none
// A character's request is first registered at the input; its tokens are then written
// into the result queue, whose head offers the first token to the output.
// Throughput: one character per cycle while the queue has room; a character that
// yields a text and a markup token pushes both, which the four-entry queue absorbs.
// The input stalls while more than two tokens wait in the queue.
// Reset (rst, synchronous) clears the tokenizer state and empties the result queue.
module xml_markup_tokenizer_unit #(
  parameter int unsigned POSITION_WIDTH = xmltok_pkg::PositionWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_byte,
  input  wire logic        start_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic [7:0]       mark_char,
  output logic             last_of_run
);
  import xmltok_pkg::*;

  push_req_t push;
  logic      room;
  token_t    head_tok;

  xmltok_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_byte    (char_byte),
    .start_of_text(start_of_text),
    .room         (room),
    .push         (push)
  );

  xmltok_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head_tok (head_tok)
  );

  assign token_kind   = head_tok.kind;
  assign token_start  = head_tok.start;
  assign token_length = head_tok.length;
  assign mark_char    = head_tok.mark;
  assign last_of_run  = head_tok.last;

endmodule
`default_nettype wire
